// File: rtl/core/wls_pkg.sv
`default_nettype none
package wls_pkg;

   // Field widths of the channels and the configuration port
   localparam int OP_W      = 2;
   localparam int CHAN_W    = 4;
   localparam int TS_W      = 32;
   localparam int KIND_W    = 1;
   localparam int CNT_OUT_W = 16;
   localparam int STAT_W    = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;
   localparam int WIN_W     = 16;
   localparam int ACT_W     = 5;

   // Running total width and the divider's step counter
   localparam int TOTAL_BITS = 48;
   localparam int DIV_CNT_W  = $clog2(TOTAL_BITS + 1);

   // Parameter defaults
   localparam int CHANNELS_DEFAULT   = 16;
   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Summary kinds
   localparam logic [KIND_W-1:0] KIND_CLOSED = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 1'b1;

   localparam logic [WIN_W-1:0] WINDOW_LENGTH_RESET   = 16'd1000;
   localparam logic [ACT_W-1:0] ACTIVE_CHANNELS_RESET = 5'd0;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAN_W-1:0] channel;
      logic [TS_W-1:0]   timestamp;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]    channel_out;
      logic [KIND_W-1:0]    kind;
      logic [CNT_OUT_W-1:0] sample_count;
      logic [STAT_W-1:0]    min_time;
      logic [STAT_W-1:0]    max_time;
      logic [STAT_W-1:0]    average_time;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic start_wr;
      logic stats_rd;
      logic capture;
      logic commit;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic req_start;
      logic req_stats;
      logic emit;
      logic div_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/core/wls_ram.sv
`default_nettype none
module wls_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/wls_ctrl.sv
`default_nettype none
module wls_ctrl import wls_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch    = 1'b1;
               cmd.start_wr = st.req_start;
               cmd.stats_rd = st.req_stats;
               if (st.req_stats) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.commit    = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = st.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the result register can take the beat
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/core/wls_dpath.sv
`default_nettype none
module wls_dpath import wls_pkg::*; #(
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire cmd_type              cmd,
   output status_type                st
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MIN_LO  = 0;
   localparam int MAX_LO  = TIME_BITS;
   localparam int TOT_LO  = 2 * TIME_BITS;
   localparam int CNT_LO  = 2 * TIME_BITS + TOTAL_BITS;
   localparam int REC_W   = CNT_LO + COUNT_BITS;

   // configuration
   logic [WIN_W-1:0] window_length_ff, window_length_in;
   logic [ACT_W-1:0] active_channels_ff, active_channels_in;

   // current item
   logic [OP_W-1:0]      op_ff, op_in;
   logic [IDX_W-1:0]     chan_ff, chan_in;
   logic [TIME_BITS-1:0] ts_ff, ts_in;

   // per-channel valid bits: start time written, window not yet opened
   logic [CHANNELS-1:0] start_vld_ff, start_vld_in;
   logic [CHANNELS-1:0] fresh_ff, fresh_in;

   // snapshot of the channel's state
   logic [TIME_BITS-1:0]  dt_ff, dt_in;
   logic                  fresh_cur_ff, fresh_cur_in;
   logic [TIME_BITS-1:0]  old_min_ff, old_min_in;
   logic [TIME_BITS-1:0]  old_max_ff, old_max_in;
   logic [TOTAL_BITS-1:0] old_total_ff, old_total_in;
   logic [COUNT_BITS-1:0] old_count_ff, old_count_in;

   // divider
   logic [COUNT_BITS-1:0] div_rem_ff, div_rem_in;
   logic [TOTAL_BITS-1:0] div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]     req_idx;
   logic                 req_active;
   logic [TIME_BITS-1:0] start_q, start_v;
   logic [REC_W-1:0]     rec_q, rec_wr;
   logic                 stats_wr;
   logic                 full;
   logic [COUNT_BITS-1:0] new_count;
   logic [TOTAL_BITS:0]   sum;
   logic [TOTAL_BITS-1:0] new_total;
   logic [TIME_BITS-1:0]  new_min, new_max;
   logic [COUNT_BITS:0]   div_shift, div_diff;
   logic                  div_ge;
   logic [TOTAL_BITS-1:0] average;

   assign req_idx    = IDX_W'(req_payload.channel);
   assign req_active = (32'(req_payload.channel) < 32'(CHANNELS)) &&
                       ({1'b0, req_payload.channel} < active_channels_ff);

   wls_ram #(.WIDTH(TIME_BITS), .DEPTH(CHANNELS)) u_start_ram (
      .clock   (clock),
      .wr_en   (cmd.start_wr),
      .wr_addr (req_idx),
      .wr_data (TIME_BITS'(req_payload.timestamp)),
      .rd_en   (cmd.stats_rd),
      .rd_addr (req_idx),
      .rd_data (start_q)
   );

   wls_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_wr),
      .wr_addr (chan_ff),
      .wr_data (rec_wr),
      .rd_en   (cmd.stats_rd),
      .rd_addr (req_idx),
      .rd_data (rec_q)
   );

   assign start_v = start_vld_ff[chan_ff] ? start_q : '0;

   // window update from the snapshot
   always_comb begin
      full = fresh_cur_ff || (32'(old_count_ff) >= 32'(window_length_ff));
      sum  = {1'b0, old_total_ff} + (TOTAL_BITS + 1)'(dt_ff);
      if (full) begin
         new_count = COUNT_BITS'(1);
         new_total = TOTAL_BITS'(dt_ff);
         new_min   = dt_ff;
         new_max   = dt_ff;
      end else begin
         new_count = (&old_count_ff) ? old_count_ff : old_count_ff + COUNT_BITS'(1);
         new_total = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
         new_min   = (dt_ff < old_min_ff) ? dt_ff : old_min_ff;
         new_max   = (dt_ff > old_max_ff) ? dt_ff : old_max_ff;
      end
      rec_wr   = {new_count, new_total, new_max, new_min};
      stats_wr = cmd.commit && (op_ff == OP_END);
   end

   // one quotient bit per step
   always_comb begin
      div_shift = {div_rem_ff, div_quo_ff[TOTAL_BITS-1]};
      div_diff  = div_shift - {1'b0, old_count_ff};
      div_ge    = (div_shift >= {1'b0, old_count_ff});
      average   = (old_count_ff == '0) ? '0 : div_quo_ff;
   end

   always_comb begin
      window_length_in   = window_length_ff;
      active_channels_in = active_channels_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:   window_length_in   = csr_wdata;
            CSR_ACTIVE_CHANNELS: active_channels_in = csr_wdata[ACT_W-1:0];
            default: ;
         endcase
      end

      op_in   = cmd.latch ? req_payload.op : op_ff;
      chan_in = cmd.latch ? req_idx : chan_ff;
      ts_in   = cmd.latch ? TIME_BITS'(req_payload.timestamp) : ts_ff;

      start_vld_in = start_vld_ff;
      if (cmd.start_wr) begin
         start_vld_in[req_idx] = 1'b1;
      end
      fresh_in = fresh_ff;
      if (stats_wr) begin
         fresh_in[chan_ff] = 1'b0;
      end

      dt_in        = dt_ff;
      fresh_cur_in = fresh_cur_ff;
      old_min_in   = old_min_ff;
      old_max_in   = old_max_ff;
      old_total_in = old_total_ff;
      old_count_in = old_count_ff;
      if (cmd.capture) begin
         dt_in        = ts_ff - start_v;
         fresh_cur_in = fresh_ff[chan_ff];
         if (fresh_ff[chan_ff]) begin
            old_min_in   = '0;
            old_max_in   = '0;
            old_total_in = '0;
            old_count_in = '0;
         end else begin
            old_min_in   = rec_q[MIN_LO +: TIME_BITS];
            old_max_in   = rec_q[MAX_LO +: TIME_BITS];
            old_total_in = rec_q[TOT_LO +: TOTAL_BITS];
            old_count_in = rec_q[CNT_LO +: COUNT_BITS];
         end
      end

      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_rem_in = '0;
         div_quo_in = old_total_ff;
         div_cnt_in = DIV_CNT_W'(TOTAL_BITS);
      end else if (cmd.div_step && (div_cnt_ff != '0)) begin
         div_rem_in = div_ge ? div_diff[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
         div_quo_in = {div_quo_ff[TOTAL_BITS-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.channel_out  = CHAN_W'(chan_ff);
         rsp_data_in.kind         = (op_ff == OP_READ) ? KIND_READ : KIND_CLOSED;
         rsp_data_in.sample_count = CNT_OUT_W'(old_count_ff);
         rsp_data_in.min_time     = STAT_W'(old_min_ff);
         rsp_data_in.max_time     = STAT_W'(old_max_ff);
         rsp_data_in.average_time = STAT_W'(average);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= WINDOW_LENGTH_RESET;
         active_channels_ff <= ACTIVE_CHANNELS_RESET;
         start_vld_ff       <= '0;
         fresh_ff           <= '1;
         div_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         window_length_ff   <= window_length_in;
         active_channels_ff <= active_channels_in;
         start_vld_ff       <= start_vld_in;
         fresh_ff           <= fresh_in;
         div_cnt_ff         <= div_cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      chan_ff      <= chan_in;
      ts_ff        <= ts_in;
      dt_ff        <= dt_in;
      fresh_cur_ff <= fresh_cur_in;
      old_min_ff   <= old_min_in;
      old_max_ff   <= old_max_in;
      old_total_ff <= old_total_in;
      old_count_ff <= old_count_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign st.req_start = req_active && (req_payload.op == OP_START);
   assign st.req_stats = req_active &&
                         ((req_payload.op == OP_END) || (req_payload.op == OP_READ));
   assign st.emit      = (op_ff == OP_READ) ||
                         ((op_ff == OP_END) && full && (old_total_ff != '0));
   assign st.div_done  = (div_cnt_ff == '0);
   assign st.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/windowed_latency_statistics.sv
// Sequence: a start beat writes its start time; an end beat that closes nothing passes
// the read and update states; a read or a closing end beat also runs the bit-serial
// average divider and waits for a free result register before its result is offered.
// Throughput: one beat in flight at a time; the next beat is taken while a result waits.
// Reset: synchronous, active high; every channel comes out fresh with zeroed statistics,
// window_length 1000 and active_channels 0. No clearing pass: valid bits cover the RAMs.
`default_nettype none
module windowed_latency_statistics import wls_pkg::*; #(
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request beats: start, end, read
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   // summary beats
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   // configuration writes
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // Commands from the sequencer and status back from the datapath
   cmd_type    cmd;
   status_type st;

   // Sequencer: take a beat, read channel state, update, divide, deliver
   wls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: channel RAMs, window arithmetic, divider and result register
   wls_dpath #(
      .CHANNELS   (CHANNELS),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .st          (st)
   );

endmodule
`default_nettype wire

// File: rtl/core/wls_checker.sv
`default_nettype none
module wls_checker import wls_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // reset empties the result register
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a result never appears the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && !req_stall))
      else $error("result too soon after request");

   // a closed window always holds at least one sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_CLOSED) |-> rsp_payload.sample_count != '0)
      else $error("closed-window summary with no samples");

endmodule

bind windowed_latency_statistics wls_checker u_wls_checker (.*);
`default_nettype wire

// File: verif/wls_latency_checker.sv
`timescale 1ns / 100ps
module wls_latency_checker import wls_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        closed_seen,
   output int                        read_seen
);

   localparam int NCHAN = CHANNELS_DEFAULT;

   // Per-channel window state
   logic [TS_W-1:0]       start_stamp  [NCHAN];
   logic [STAT_W-1:0]     shortest     [NCHAN];
   logic [STAT_W-1:0]     longest      [NCHAN];
   logic [TOTAL_BITS-1:0] interval_sum [NCHAN];
   logic [CNT_OUT_W-1:0]  window_fill  [NCHAN];
   bit                    fresh        [NCHAN];

   logic [WIN_W-1:0] window_len;
   logic [ACT_W-1:0] active_count;

   rsp_type expected_summaries [$];

   function automatic rsp_type summary_of(input int unsigned ch,
                                          input logic [KIND_W-1:0] kind);
      rsp_type               s;
      logic [TOTAL_BITS-1:0] mean;
      mean = '0;
      if (window_fill[ch] != '0)
         mean = interval_sum[ch] / TOTAL_BITS'(window_fill[ch]);
      s.channel_out  = ch[CHAN_W-1:0];
      s.kind         = kind;
      s.sample_count = window_fill[ch];
      s.min_time     = shortest[ch];
      s.max_time     = longest[ch];
      s.average_time = mean[STAT_W-1:0];
      return s;
   endfunction

   // append one predicted summary at the tail of the queue
   task automatic enqueue_summary(input rsp_type s);
      expected_summaries = {expected_summaries, s};
   endtask

   task automatic track_event(input req_type beat);
      int unsigned           ch;
      logic [TS_W-1:0]       interval;
      logic [TOTAL_BITS:0]   sum;
      ch = 32'(beat.channel);
      // drop beats for channels outside the active range
      if ({1'b0, beat.channel} < active_count) begin
         case (beat.op)
            OP_START: start_stamp[ch] = beat.timestamp;
            OP_END: begin
               interval = beat.timestamp - start_stamp[ch];
               if (fresh[ch] || window_fill[ch] >= window_len) begin
                  // a window with a zero total closes silently
                  if (interval_sum[ch] != '0)
                     enqueue_summary(summary_of(ch, KIND_CLOSED));
                  fresh[ch]        = 1'b0;
                  shortest[ch]     = interval;
                  longest[ch]      = interval;
                  interval_sum[ch] = TOTAL_BITS'(interval);
                  window_fill[ch]  = CNT_OUT_W'(1);
               end else begin
                  if (window_fill[ch] != '1)
                     window_fill[ch] = window_fill[ch] + CNT_OUT_W'(1);
                  sum = {1'b0, interval_sum[ch]} + (TOTAL_BITS + 1)'(interval);
                  interval_sum[ch] = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                  if (longest[ch] < interval)
                     longest[ch] = interval;
                  if (shortest[ch] > interval)
                     shortest[ch] = interval;
               end
            end
            OP_READ: enqueue_summary(summary_of(ch, KIND_READ));
            default: ;
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NCHAN; i++) begin
            start_stamp[i]  = '0;
            shortest[i]     = '0;
            longest[i]      = '0;
            interval_sum[i] = '0;
            window_fill[i]  = '0;
            fresh[i]        = 1'b1;
         end
         window_len   = WINDOW_LENGTH_RESET;
         active_count = ACTIVE_CHANNELS_RESET;
         expected_summaries.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_WINDOW_LENGTH)
               window_len = csr_wdata[WIN_W-1:0];
            else if (csr_index == CSR_ACTIVE_CHANNELS)
               active_count = csr_wdata[ACT_W-1:0];
         end
         // compare before predicting: a result beat always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $error("unexpected summary beat for channel %0d", rsp_payload.channel_out);
               fail_count++;
            end else begin
               want = expected_summaries.pop_front();
               check_field("channel_out", 32'(want.channel_out),
                           32'(rsp_payload.channel_out));
               check_field("kind", 32'(want.kind), 32'(rsp_payload.kind));
               check_field("sample_count", 32'(want.sample_count),
                           32'(rsp_payload.sample_count));
               check_field("min_time", want.min_time, rsp_payload.min_time);
               check_field("max_time", want.max_time, rsp_payload.max_time);
               check_field("average_time", want.average_time, rsp_payload.average_time);
               if (want.kind == KIND_CLOSED)
                  closed_seen++;
               else
                  read_seen++;
            end
         end
         if (req_valid && !req_stall)
            track_event(req_payload);
      end
      pending = expected_summaries.size();
   end

endmodule

// File: verif/tb_windowed_latency_statistics.sv
`timescale 1ns / 100ps
module tb_windowed_latency_statistics;
   import wls_pkg::*;

   // Unused operation code: the block must swallow it without a result
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // Settle time after draining: longest request-to-result latency plus margin
   localparam int SETTLE_CYCLES = 60;
   // Request beats per random phase that the block actually acts on
   localparam int PHASE_BEATS   = 50;
   localparam int PHASES        = 8;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]     csr_wdata   = '0;

   int fail_count;
   int pending;
   int closed_seen;
   int read_seen;

   // Stimulus-side bookkeeping, used only to shape well-formed start/end pairs
   bit              start_open [CHANNELS_DEFAULT];
   logic [TS_W-1:0] start_at   [CHANNELS_DEFAULT];
   int              beats_sent;
   bit              gapless;
   bit              stall_free;
   int unsigned     stall_run;

   windowed_latency_statistics u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   wls_latency_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .closed_seen (closed_seen),
      .read_seen   (read_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: alternate free runs and stall runs, mostly short,
   // now and then a long one. Hold stall off entirely while stall_free is set.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         if (stall_free || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(1, 20);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 4);
         end
      end else begin
         stall_run = stall_run - 1;
      end
   end

   // Offer one request beat at the falling edge and hold it until the block takes it.
   // Afterwards either leave valid high for a back-to-back beat or open a gap.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                            input logic [TS_W-1:0] stamp);
      req_type     beat;
      int unsigned gap;
      int unsigned roll;
      beat.op        = op;
      beat.channel   = ch;
      beat.timestamp = stamp;
      @(negedge clock);
      req_payload <= beat;
      req_valid   <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      beats_sent++;
      roll = $urandom_range(0, 99);
      if (gapless || roll < 50)
         gap = 0;
      else if (roll < 85)
         gap = $urandom_range(1, 3);
      else if (roll < 97)
         gap = $urandom_range(4, 15);
      else
         gap = $urandom_range(30, 120);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid, wait for every predicted summary to arrive, then let a silent end
   // beat still in flight finish before anything else touches the block.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random request. Most beats form start/end pairs per channel; the rest are
   // reads, stray ends, restarts, unused codes and beats to inactive channels.
   task automatic send_random_item(input int unsigned active, output bit counted);
      logic [CHAN_W-1:0] ch;
      logic [OP_W-1:0]   op;
      logic [TS_W-1:0]   stamp;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      if (roll < 8 || active == 0)
         ch = CHAN_W'($urandom_range(0, 15));
      else
         ch = CHAN_W'($urandom_range(0, (active > 16 ? 16 : active) - 1));
      roll  = $urandom_range(0, 99);
      stamp = $urandom;
      if (roll < 4)
         op = OP_UNUSED;
      else if (roll < 20)
         op = OP_READ;
      else if (start_open[ch])
         op = (roll < 87) ? OP_END : OP_START;
      else
         op = (roll < 87) ? OP_START : OP_END;
      // intervals: mostly short, some medium, a few spanning the whole time range
      if (op == OP_END && start_open[ch]) begin
         roll = $urandom_range(0, 99);
         if (roll < 5)
            stamp = start_at[ch];
         else if (roll < 70)
            stamp = start_at[ch] + $urandom_range(1, 1000);
         else if (roll < 90)
            stamp = start_at[ch] + $urandom_range(1000, 1 << 24);
         else
            stamp = start_at[ch] + $urandom;
      end
      if (op == OP_START) begin
         start_open[ch] = 1'b1;
         start_at[ch]   = stamp;
      end else if (op == OP_END) begin
         start_open[ch] = 1'b0;
      end
      send_beat(op, ch, stamp);
      counted = (32'(ch) < active) && (op != OP_UNUSED);
   endtask

   initial begin
      int unsigned      done;
      bit               counted;
      logic [WIN_W-1:0] win;
      logic [ACT_W-1:0] act;
      logic [CSR_W-1:0] act_word;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings leave every channel inactive: these beats must vanish
      send_beat(OP_START, 4'd0, 32'hFFFF_FFFF);
      send_beat(OP_READ, 4'd15, 32'h0000_0000);
      wait_drained();
      // write zero active channels explicitly, with junk above the field
      write_reg(CSR_ACTIVE_CHANNELS, 16'hFFE0);
      write_reg(CSR_WINDOW_LENGTH, 16'd3);
      write_reg(CSR_ACTIVE_CHANNELS, 16'd4);

      // Channel 0: fresh read, silent first end, wrapped and full-range intervals,
      // then a full window that closes with a summary
      send_beat(OP_READ, 4'd0, 32'h0000_0000);
      send_beat(OP_END, 4'd0, 32'd100);
      send_beat(OP_START, 4'd0, 32'hFFFF_FFF0);
      send_beat(OP_END, 4'd0, 32'h0000_0010);
      send_beat(OP_START, 4'd0, 32'h0000_0000);
      send_beat(OP_END, 4'd0, 32'hFFFF_FFFF);
      send_beat(OP_END, 4'd0, 32'd5);
      send_beat(OP_READ, 4'd0, 32'h1234_5678);
      send_beat(OP_UNUSED, 4'd0, 32'hA5A5_A5A5);
      // inactive channels
      send_beat(OP_START, 4'd4, 32'h5555_5555);
      send_beat(OP_READ, 4'd15, 32'hAAAA_AAAA);
      // Channel 1: zero intervals only, so the full window closes without a summary
      send_beat(OP_START, 4'd1, 32'd50);
      send_beat(OP_END, 4'd1, 32'd50);
      send_beat(OP_END, 4'd1, 32'd50);
      send_beat(OP_END, 4'd1, 32'd50);
      send_beat(OP_END, 4'd1, 32'd50);
      send_beat(OP_READ, 4'd1, 32'd50);
      wait_drained();

      // Zero window length: every end beat finds the window full
      write_reg(CSR_WINDOW_LENGTH, 16'd0);
      write_reg(CSR_ACTIVE_CHANNELS, 16'd16);
      send_beat(OP_START, 4'd15, 32'd1000);
      send_beat(OP_END, 4'd15, 32'd1007);
      send_beat(OP_END, 4'd15, 32'd1010);
      send_beat(OP_READ, 4'd15, 32'd1010);
      wait_drained();

      // Random phases over a spread of settings, extremes among them
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin win = 16'd1;     act = 5'd16; end
            1: begin win = 16'd2;     act = 5'd31; end
            2: begin win = 16'd5;     act = 5'd8;  end
            3: begin win = 16'd0;     act = 5'd3;  end
            4: begin win = 16'd4;     act = 5'd16; end
            5: begin win = 16'd65535; act = 5'd16; end
            6: begin win = 16'd7;     act = 5'd1;  end
            default: begin win = 16'd3; act = 5'd12; end
         endcase
         act_word = CSR_W'($urandom);
         act_word[ACT_W-1:0] = act;
         write_reg(CSR_WINDOW_LENGTH, win);
         write_reg(CSR_ACTIVE_CHANNELS, act_word);
         // one phase with the sender never idle, one with the receiver never stalling
         gapless    = (p == 1);
         stall_free = (p == 2);
         done = 0;
         while (done < PHASE_BEATS) begin
            send_random_item(32'(act), counted);
            if (counted) begin
               done++;
               // pause mid-phase until the block has delivered everything
               if (p == 4 && done == 20)
                  wait_drained();
            end
         end
         wait_drained();
      end

      $display("Drove %0d request beats: directed cases plus %0d random phases,",
               beats_sent, PHASES);
      $display("window lengths 0..65535, active channels 0..31; %0d closed, %0d read summaries.",
               closed_seen, read_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
